/* rtl/assert_macros.svh */
// Assertion macros for the RTL of the palette pixel expander.
// Depends on nothing; included by the top unit, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HPX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/hpx_pkg.sv */
// Package of the palette pixel expander: word types, opcodes, register codes, states.
// Depends on nothing; used by the row store and the top unit.
`timescale 1ns / 1ps

package hpx_pkg;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [2:0]  channel;
        logic [7:0]  row_index;
        logic [8:0]  table_length;
        logic [7:0]  line_count;
        logic [7:0]  palette_index;
        logic [14:0] color_word;
    } t_in_word;

    typedef struct packed {
        logic [14:0] snes_color;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_of_line;
        logic        last_of_image;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  line_count;
        logic [7:0]  palette_index;
        logic [14:0] color_word;
    } t_row;

    localparam int RowBits = $bits(t_row);

    localparam logic [2:0] OP_BASE_WRITE = 3'd0;
    localparam logic [2:0] OP_ROW_WRITE  = 3'd1;
    localparam logic [2:0] OP_SET_LENGTH = 3'd2;
    localparam logic [2:0] OP_START      = 3'd3;
    localparam logic [2:0] OP_PIXEL      = 3'd4;

    localparam logic [1:0] REG_WIDTH    = 2'd0;
    localparam logic [1:0] REG_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_CHANNELS = 2'd2;

    localparam logic [14:0] RED_MASK   = 15'h001f;
    localparam logic [14:0] GREEN_MASK = 15'h03e0;
    localparam logic [14:0] BLUE_MASK  = 15'h7c00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COPY,
        S_CH,
        S_CH_WR,
        S_PIX,
        S_OUT
    } t_state;

endpackage

/* rtl/hpx_pal_mem.sv */
// Base and working palettes: two 1W1R synchronous memories with registered reads.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module hpx_pal_mem #(
    parameter int ENTRIES = 256,
    parameter int AW      = 8
) (
    input  logic          i_clk,
    input  logic          i_base_we,
    input  logic [AW-1:0] i_base_waddr,
    input  logic [14:0]   i_base_wdata,
    input  logic [AW-1:0] i_base_raddr,
    output logic [14:0]   o_base_rdata,
    input  logic          i_work_we,
    input  logic [AW-1:0] i_work_waddr,
    input  logic [14:0]   i_work_wdata,
    input  logic          i_work_re,
    input  logic [AW-1:0] i_work_raddr,
    output logic [14:0]   o_work_rdata
);

    logic [14:0] r_base [ENTRIES];
    logic [14:0] r_work [ENTRIES];
    logic [14:0] r_base_rd;
    logic [14:0] r_work_rd;

    always_ff @(posedge i_clk) begin
        if (i_base_we) begin
            r_base[i_base_waddr] <= i_base_wdata;
        end
        r_base_rd <= r_base[i_base_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_work_we) begin
            r_work[i_work_waddr] <= i_work_wdata;
        end
        if (i_work_re) begin
            r_work_rd <= r_work[i_work_raddr];
        end
    end

    assign o_base_rdata = r_base_rd;
    assign o_work_rdata = r_work_rd;

endmodule

/* rtl/hpx_row_mem.sv */
// HDMA row store: one 1W1R synchronous memory, rows of all channels laid end to end.
// Depends on hpx_pkg for the row layout.
`timescale 1ns / 1ps

module hpx_row_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  hpx_pkg::t_row      i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output hpx_pkg::t_row      o_rdata
);

    hpx_pkg::t_row r_mem [DEPTH];
    hpx_pkg::t_row r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    assign o_rdata = r_rd;

endmodule

/* rtl/hdma_palette_pixel_expander_unit.sv */
// Palette pixel expander with per-line HDMA palette rewrites. A pixel word is read in S_PIX,
// enters the output register from S_OUT and reopens the input as it enters. At column 0 with
// channels active it first visits S_CH for each channel, plus S_CH_WR for each fetching channel,
// and a last S_CH visit closes the pass; a stalled output holds the block until the word leaves.
// A start word closes the input while it copies the base palette into the working one; load
// words are stored on acceptance. Reset is synchronous, active low; stores are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hdma_palette_pixel_expander_unit #(
    parameter int CHANNELS        = 8,
    parameter int TABLE_ROWS      = 256,
    parameter int PALETTE_ENTRIES = 256,
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Input word channel.
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hpx_pkg::t_in_word   i_in_word,
    // Output word channel.
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hpx_pkg::t_out_word  o_out_word,
    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Derived widths. Every index carries exactly the bits its store needs.
    localparam int PAW    = $clog2(PALETTE_ENTRIES);
    localparam int PCW    = $clog2(PALETTE_ENTRIES + 1);
    localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NW     = $clog2(CHANNELS + 1);
    localparam int RDEPTH = CHANNELS * TABLE_ROWS;
    localparam int RAW    = $clog2(RDEPTH);

    // Configuration registers, reset to their documented defaults.
    logic [8:0] r_width;
    logic [8:0] r_height;
    logic [3:0] r_active;

    // Per-channel state: small register files indexed by the channel in hand.
    logic [8:0] r_len [CHANNELS];
    logic [7:0] r_ctr [CHANNELS];
    logic [8:0] r_pos [CHANNELS];

    // Image position and run flag.
    logic [7:0] r_col;
    logic [7:0] r_line;
    logic       r_running;

    // Sequencer state and working registers.
    hpx_pkg::t_state r_state, n_state;
    logic [PCW-1:0]  r_copy_cnt;
    logic [NW-1:0]   r_ch;
    logic [7:0]      r_pix_idx;

    hpx_pkg::t_out_word r_out;
    logic               r_out_valid;

    // Memory connections.
    logic [14:0]     base_rdata;
    logic [14:0]     work_rdata;
    hpx_pkg::t_row   row_rdata;
    logic            work_we;
    logic [PAW-1:0]  work_waddr;
    logic [14:0]     work_wdata;
    logic            work_re;
    logic [RAW-1:0]  row_raddr;
    logic [RAW-1:0]  row_waddr;
    logic            row_we;
    logic            base_we;

    // Decoded values.
    logic            in_acc;
    logic            out_free;
    logic            cfg_wr;
    logic [NW-1:0]   nch;
    logic [8:0]      width_c;
    logic [8:0]      height_c;
    logic            end_line;
    logic            end_image;
    logic [CW-1:0]   ch_idx;
    logic            ch_fetch;
    logic            pix_in_range;
    logic [14:0]     pix_color;
    logic            row_pal_ok;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;

    // Sizes: zero counts as one, anything above the maximum saturates; the channel count only saturates.
    always_comb begin
        if (r_width == 9'd0) begin
            width_c = 9'd1;
        end else if (r_width > 9'(MAX_WIDTH)) begin
            width_c = 9'(MAX_WIDTH);
        end else begin
            width_c = r_width;
        end
        if (r_height == 9'd0) begin
            height_c = 9'd1;
        end else if (r_height > 9'(MAX_HEIGHT)) begin
            height_c = 9'(MAX_HEIGHT);
        end else begin
            height_c = r_height;
        end
        if (r_active > 4'(CHANNELS)) begin
            nch = NW'(CHANNELS);
        end else begin
            nch = NW'(r_active);
        end
    end

    // A column or line already past the end, after a register was lowered
    // mid-image, still counts as the last one.
    assign end_line  = {1'b0, r_col} >= (width_c - 9'd1);
    assign end_image = end_line && ({1'b0, r_line} >= (height_c - 9'd1));

    assign ch_idx   = r_ch[CW-1:0];
    assign ch_fetch = (r_ctr[ch_idx] == 8'd0) && (r_pos[ch_idx] < r_len[ch_idx]);

    // The row is used only while its position is below the table length, which never exceeds TABLE_ROWS.
    assign row_raddr  = RAW'(int'(ch_idx) * TABLE_ROWS + int'(r_pos[ch_idx]));
    assign row_pal_ok = 9'(row_rdata.palette_index) < 9'(PALETTE_ENTRIES);

    assign pix_in_range = 9'(r_pix_idx) < 9'(PALETTE_ENTRIES);
    assign pix_color    = pix_in_range ? work_rdata : 15'd0;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hpx_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.opcode == hpx_pkg::OP_START) begin
                        n_state = hpx_pkg::S_COPY;
                    end else if (i_in_word.opcode == hpx_pkg::OP_PIXEL && r_running) begin
                        if (r_col == 8'd0 && nch != '0) begin
                            n_state = hpx_pkg::S_CH;
                        end else begin
                            n_state = hpx_pkg::S_PIX;
                        end
                    end
                end
            end
            hpx_pkg::S_COPY: begin
                if (r_copy_cnt == PCW'(PALETTE_ENTRIES)) begin
                    n_state = hpx_pkg::S_IDLE;
                end
            end
            hpx_pkg::S_CH: begin
                if (r_ch == nch) begin
                    n_state = hpx_pkg::S_PIX;
                end else if (ch_fetch) begin
                    n_state = hpx_pkg::S_CH_WR;
                end
            end
            hpx_pkg::S_CH_WR: n_state = hpx_pkg::S_CH;
            hpx_pkg::S_PIX:   n_state = hpx_pkg::S_OUT;
            hpx_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = hpx_pkg::S_IDLE;
                end
            end
            default: n_state = hpx_pkg::S_IDLE;
        endcase
    end

    // Output and memory-control logic of the sequencer.
    always_comb begin
        o_in_ready = 1'b0;
        work_we    = 1'b0;
        work_waddr = r_copy_cnt[PAW-1:0] - PAW'(1);
        work_wdata = base_rdata;
        work_re    = 1'b0;
        unique case (r_state)
            hpx_pkg::S_IDLE: o_in_ready = 1'b1;
            hpx_pkg::S_COPY: begin
                // The base entry read in the previous cycle lands one behind the count.
                work_we = (r_copy_cnt != '0);
            end
            hpx_pkg::S_CH_WR: begin
                work_we    = row_pal_ok;
                work_waddr = row_rdata.palette_index[PAW-1:0];
                work_wdata = row_rdata.color_word;
            end
            hpx_pkg::S_PIX: work_re = 1'b1;
            default: begin
            end
        endcase
    end

    // Load words go straight into the stores on acceptance.
    assign base_we = in_acc && i_in_word.opcode == hpx_pkg::OP_BASE_WRITE
                     && 9'(i_in_word.palette_index) < 9'(PALETTE_ENTRIES);
    assign row_we  = in_acc && i_in_word.opcode == hpx_pkg::OP_ROW_WRITE
                     && 32'(i_in_word.channel) < CHANNELS
                     && 32'(i_in_word.row_index) < TABLE_ROWS;
    assign row_waddr = RAW'(int'(i_in_word.channel) * TABLE_ROWS + int'(i_in_word.row_index));

    hpx_pal_mem #(
        .ENTRIES (PALETTE_ENTRIES),
        .AW      (PAW)
    ) u_pal (
        .i_clk        (i_clk),
        .i_base_we    (base_we),
        .i_base_waddr (i_in_word.palette_index[PAW-1:0]),
        .i_base_wdata (i_in_word.color_word),
        .i_base_raddr (r_copy_cnt[PAW-1:0]),
        .o_base_rdata (base_rdata),
        .i_work_we    (work_we),
        .i_work_waddr (work_waddr),
        .i_work_wdata (work_wdata),
        .i_work_re    (work_re),
        .i_work_raddr (r_pix_idx[PAW-1:0]),
        .o_work_rdata (work_rdata)
    );

    hpx_row_mem #(
        .DEPTH (RDEPTH),
        .AW    (RAW)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (hpx_pkg::t_row'{line_count:    i_in_word.line_count,
                                  palette_index: i_in_word.palette_index,
                                  color_word:    i_in_word.color_word}),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // Configuration registers; only word-aligned addresses of the list are decoded for writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd224;
            r_active <= 4'd0;
        end else if (cfg_wr && paddr[1:0] == 2'd0) begin
            unique case (paddr[3:2])
                hpx_pkg::REG_WIDTH:    r_width  <= pwdata[8:0];
                hpx_pkg::REG_HEIGHT:   r_height <= pwdata[8:0];
                hpx_pkg::REG_CHANNELS: r_active <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (paddr[3:2])
            hpx_pkg::REG_WIDTH:    prdata = {23'd0, r_width};
            hpx_pkg::REG_HEIGHT:   prdata = {23'd0, r_height};
            hpx_pkg::REG_CHANNELS: prdata = {28'd0, r_active};
            default:               prdata = 32'd0;
        endcase
    end

    // Sequencer, counters and per-channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpx_pkg::S_IDLE;
            r_copy_cnt  <= '0;
            r_ch        <= '0;
            r_col       <= 8'd0;
            r_line      <= 8'd0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_len[i] <= 9'd0;
                r_ctr[i] <= 8'd0;
                r_pos[i] <= 9'd0;
            end
        end else begin
            r_state <= n_state;
            // A new word is loaded as the old one leaves, so valid stays high then.
            if (r_state == hpx_pkg::S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                hpx_pkg::S_IDLE: begin
                    r_copy_cnt <= '0;
                    r_ch       <= '0;
                    if (in_acc) begin
                        r_pix_idx <= i_in_word.palette_index;
                        if (i_in_word.opcode == hpx_pkg::OP_SET_LENGTH
                            && 32'(i_in_word.channel) < CHANNELS) begin
                            r_len[i_in_word.channel[CW-1:0]] <=
                                (i_in_word.table_length > 9'(TABLE_ROWS)) ?
                                9'(TABLE_ROWS) : i_in_word.table_length;
                        end
                        if (i_in_word.opcode == hpx_pkg::OP_START) begin
                            r_col     <= 8'd0;
                            r_line    <= 8'd0;
                            r_running <= 1'b1;
                            for (int i = 0; i < CHANNELS; i++) begin
                                r_ctr[i] <= 8'd0;
                                r_pos[i] <= 9'd0;
                            end
                        end
                    end
                end
                hpx_pkg::S_COPY: begin
                    r_copy_cnt <= r_copy_cnt + PCW'(1);
                end
                hpx_pkg::S_CH: begin
                    // A channel with nothing to fetch only counts down, wrapping.
                    if (r_ch != nch && !ch_fetch) begin
                        r_ctr[ch_idx] <= r_ctr[ch_idx] - 8'd1;
                        r_ch          <= r_ch + NW'(1);
                    end
                end
                hpx_pkg::S_CH_WR: begin
                    r_ctr[ch_idx] <= row_rdata.line_count - 8'd1;
                    if (row_rdata.line_count != 8'd0) begin
                        r_pos[ch_idx] <= r_pos[ch_idx] + 9'd1;
                    end else begin
                        // A zero count ends the table for this channel.
                        r_pos[ch_idx] <= r_len[ch_idx];
                    end
                    r_ch <= r_ch + NW'(1);
                end
                hpx_pkg::S_OUT: begin
                    if (out_free) begin
                        if (end_line) begin
                            r_col <= 8'd0;
                            if (end_image) begin
                                r_line    <= 8'd0;
                                r_running <= 1'b0;
                            end else begin
                                r_line <= r_line + 8'd1;
                            end
                        end else begin
                            r_col <= r_col + 8'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output word register: payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (r_state == hpx_pkg::S_OUT && out_free) begin
            r_out.snes_color    <= pix_color;
            r_out.red           <= {pix_color[4:0], 3'b000};
            r_out.green         <= {pix_color[9:5], 3'b000};
            r_out.blue          <= {pix_color[14:10], 3'b000};
            r_out.last_of_line  <= end_line;
            r_out.last_of_image <= end_image;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // A pixel word that arrives with no image running is dropped at once.
    `HPX_ASSERT_NEXT(a_idle_pixel_dropped, i_clk, i_rst_n,
        in_acc && i_in_word.opcode == hpx_pkg::OP_PIXEL && !r_running,
        r_state == hpx_pkg::S_IDLE)
    // A new output word is only ever loaded from the output state.
    `HPX_ASSERT_NOW(a_out_from_out_state, i_clk, i_rst_n,
        $rose(o_out_valid),
        $past(r_state) == hpx_pkg::S_OUT)
    // The copy sweep never runs past the palette.
    `HPX_ASSERT_NOW(a_copy_in_range, i_clk, i_rst_n,
        r_state == hpx_pkg::S_COPY,
        r_copy_cnt <= PCW'(PALETTE_ENTRIES))
    // Channel processing never visits a channel beyond the active count.
    `HPX_ASSERT_NOW(a_channel_in_range, i_clk, i_rst_n,
        r_state == hpx_pkg::S_CH_WR,
        r_ch < nch)

endmodule
